[design/nbr_pkg.sv]
// ----------------------------------------------------------------------------
// nbr_pkg
// Shared types, codes and helpers for the neighbour table with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package nbr_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int PORT_COUNT_DEF    = 4;

  localparam int PORT_W = 2;
  localparam int AGE_W  = 10;
  localparam int OUT_W  = 5;

  localparam logic [AGE_W-1:0] AGE_MAX     = '1;
  localparam logic [OUT_W-1:0] OUT_SAT     = '1;
  localparam int               DEAD_FACTOR = 3;

  localparam logic [7:0] HELLO_INTERVAL_RST = 8'd5;

  // register index taken from the word address of the configuration port
  localparam logic REG_HELLO_INTERVAL = 1'b0;

  typedef enum logic {
    REQ_HELLO = 1'b0,
    REQ_TICK  = 1'b1
  } req_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [31:0]       router;
    logic [31:0]       address;
    logic [31:0]       mask;
    logic [AGE_W-1:0]  age;
  } slot_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic [15:0] v);
    if (v > 16'(OUT_SAT)) begin
      return OUT_SAT;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/nbr_ram.sv]
// ----------------------------------------------------------------------------
// nbr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/nbr_apb.sv]
// ----------------------------------------------------------------------------
// nbr_apb
// APB-style configuration register file: holds the hello interval.
// ----------------------------------------------------------------------------
`default_nettype none

module nbr_apb (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [7:0]  hello_interval
);
  import nbr_pkg::*;

  logic [7:0] hello_interval_r;
  logic       wr_xfer;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_xfer = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hello_interval_r <= HELLO_INTERVAL_RST;
    end else if (wr_xfer && reg_idx == REG_HELLO_INTERVAL) begin
      hello_interval_r <= pwdata[7:0];
    end
  end

  // byte lanes within the word are ignored
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_HELLO_INTERVAL && paddr[1:0] == paddr[1:0]) begin
      prdata = {24'd0, hello_interval_r};
    end
  end

  assign hello_interval = hello_interval_r;

endmodule

`default_nettype wire

[design/nbr_engine.sv]
// ----------------------------------------------------------------------------
// nbr_engine
// Sequencer that walks the slot RAM one entry per cycle for hellos and ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module nbr_engine #(
  parameter int TABLE_ENTRIES = nbr_pkg::TABLE_ENTRIES_DEF,
  parameter int PORT_COUNT    = nbr_pkg::PORT_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [7:0]                hello_interval,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_req_type,
  input  wire logic [nbr_pkg::PORT_W-1:0] in_port_index,
  input  wire logic [31:0]               in_router_id,
  input  wire logic [31:0]               in_source_address,
  input  wire logic [31:0]               in_network_mask,
  output logic                           out_valid,
  output logic                           out_set_changed,
  output logic                           out_was_added,
  output logic [nbr_pkg::OUT_W-1:0]      out_removed_count,
  output logic [nbr_pkg::OUT_W-1:0]      out_port_neighbors,
  output logic                           out_insert_dropped
);
  import nbr_pkg::*;

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int PIW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // control
  logic [IW-1:0]            rd_idx_r, rd_idx_nxt;
  logic                     iss_r, iss_nxt;
  logic                     proc_vld_r, proc_vld_nxt;
  logic [IW-1:0]            proc_idx_r, proc_idx_nxt;
  logic                     hit_r, hit_nxt;
  logic                     free_vld_r, free_vld_nxt;
  logic [IW-1:0]            free_idx_r, free_idx_nxt;
  logic                     oor_r, oor_nxt;
  logic [CW-1:0]            removed_r, removed_nxt;
  logic [CW-1:0]            total_r, total_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]            cnt_r [PORT_COUNT];
  logic [CW-1:0]            cnt_nxt [PORT_COUNT];
  logic                     out_vld_r, out_vld_nxt;

  // payload
  req_t              req_r, req_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic [31:0]       rid_r, rid_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       mask_r, mask_nxt;
  logic              o_chg_r, o_chg_nxt;
  logic              o_add_r, o_add_nxt;
  logic [OUT_W-1:0]  o_rem_r, o_rem_nxt;
  logic [OUT_W-1:0]  o_nbr_r, o_nbr_nxt;
  logic              o_drop_r, o_drop_nxt;

  // slot RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata;
  slot_t         ram_rdata;

  nbr_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  logic [AGE_W-1:0] limit;
  logic [AGE_W-1:0] age_inc;
  logic             expire;
  logic             slot_live;
  logic             slot_hit;
  logic [PIW-1:0]   cnt_sel;
  logic [CW-1:0]    cnt_cur;
  logic [CW-1:0]    cnt_inc;

  assign limit     = AGE_W'(DEAD_FACTOR * int'(hello_interval));
  assign age_inc   = (ram_rdata.age == AGE_MAX) ? ram_rdata.age : ram_rdata.age + AGE_W'(1);
  assign expire    = age_inc > limit;
  assign slot_live = proc_vld_r & valid_r[proc_idx_r];
  assign slot_hit  = slot_live && ram_rdata.port == port_r && ram_rdata.router == rid_r;

  // one count read port: the slot's port while ageing, the hello's port otherwise
  assign cnt_sel = (state_r == ST_SCAN && req_r == REQ_TICK) ? PIW'(ram_rdata.port)
                                                             : PIW'(port_r);
  assign cnt_cur = cnt_r[cnt_sel];
  assign cnt_inc = cnt_cur + CW'(1);

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    iss_nxt      = iss_r;
    proc_vld_nxt = proc_vld_r;
    proc_idx_nxt = proc_idx_r;
    hit_nxt      = hit_r;
    free_vld_nxt = free_vld_r;
    free_idx_nxt = free_idx_r;
    oor_nxt      = oor_r;
    removed_nxt  = removed_r;
    total_nxt    = total_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    out_vld_nxt  = 1'b0;
    req_nxt      = req_r;
    port_nxt     = port_r;
    rid_nxt      = rid_r;
    addr_nxt     = addr_r;
    mask_nxt     = mask_r;
    o_chg_nxt    = o_chg_r;
    o_add_nxt    = o_add_r;
    o_rem_nxt    = o_rem_r;
    o_nbr_nxt    = o_nbr_r;
    o_drop_nxt   = o_drop_r;
    ram_we       = 1'b0;
    ram_waddr    = proc_idx_r;
    ram_wdata    = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt      = req_t'(in_req_type);
          port_nxt     = in_port_index;
          rid_nxt      = in_router_id;
          addr_nxt     = in_source_address;
          mask_nxt     = in_network_mask;
          removed_nxt  = '0;
          hit_nxt      = 1'b0;
          free_vld_nxt = 1'b0;
          rd_idx_nxt   = '0;
          proc_vld_nxt = 1'b0;
          oor_nxt      = (req_t'(in_req_type) == REQ_HELLO) &&
                         (int'(in_port_index) >= PORT_COUNT);
          iss_nxt      = !oor_nxt;
          state_nxt    = oor_nxt ? ST_FIN : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // read one entry ahead of the one being evaluated
        proc_vld_nxt = iss_r;
        proc_idx_nxt = rd_idx_r;
        if (iss_r) begin
          rd_idx_nxt = rd_idx_r + IW'(1);
          if (rd_idx_r == LAST_IDX) begin
            iss_nxt = 1'b0;
          end
        end
        if (proc_vld_r) begin
          if (req_r == REQ_TICK) begin
            if (slot_live) begin
              if (expire) begin
                valid_nxt[proc_idx_r] = 1'b0;
                cnt_nxt[cnt_sel]      = cnt_cur - CW'(1);
                total_nxt             = total_r - CW'(1);
                removed_nxt           = removed_r + CW'(1);
              end else begin
                ram_we        = 1'b1;
                ram_wdata.age = age_inc;
              end
            end
            if (proc_idx_r == LAST_IDX) begin
              state_nxt = ST_FIN;
            end
          end else begin
            if (slot_hit) begin
              ram_we        = 1'b1;
              ram_wdata.age = '0;
              hit_nxt       = 1'b1;
              state_nxt     = ST_FIN;
            end else begin
              if (!valid_r[proc_idx_r] && !free_vld_r) begin
                free_vld_nxt = 1'b1;
                free_idx_nxt = proc_idx_r;
              end
              if (proc_idx_r == LAST_IDX) begin
                state_nxt = ST_FIN;
              end
            end
          end
        end
      end

      ST_FIN: begin
        out_vld_nxt = 1'b1;
        o_chg_nxt   = 1'b0;
        o_add_nxt   = 1'b0;
        o_rem_nxt   = '0;
        o_nbr_nxt   = '0;
        o_drop_nxt  = 1'b0;
        if (oor_r) begin
          o_nbr_nxt = '0;
        end else if (req_r == REQ_TICK) begin
          o_chg_nxt = removed_r != '0;
          o_rem_nxt = sat_out(16'(removed_r));
          o_nbr_nxt = sat_out(16'(total_r));
        end else if (hit_r) begin
          o_nbr_nxt = sat_out(16'(cnt_cur));
        end else if (free_vld_r) begin
          ram_we                = 1'b1;
          ram_waddr             = free_idx_r;
          ram_wdata.port        = port_r;
          ram_wdata.router      = rid_r;
          ram_wdata.address     = addr_r;
          ram_wdata.mask        = mask_r;
          ram_wdata.age         = '0;
          valid_nxt[free_idx_r] = 1'b1;
          cnt_nxt[cnt_sel]      = cnt_inc;
          total_nxt             = total_r + CW'(1);
          o_chg_nxt             = 1'b1;
          o_add_nxt             = 1'b1;
          o_nbr_nxt             = sat_out(16'(cnt_inc));
        end else begin
          o_drop_nxt = 1'b1;
          o_nbr_nxt  = sat_out(16'(cnt_cur));
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_idx_r   <= '0;
      iss_r      <= 1'b0;
      proc_vld_r <= 1'b0;
      proc_idx_r <= '0;
      hit_r      <= 1'b0;
      free_vld_r <= 1'b0;
      free_idx_r <= '0;
      oor_r      <= 1'b0;
      removed_r  <= '0;
      total_r    <= '0;
      valid_r    <= '0;
      out_vld_r  <= 1'b0;
      for (int p = 0; p < PORT_COUNT; p++) begin
        cnt_r[p] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      iss_r      <= iss_nxt;
      proc_vld_r <= proc_vld_nxt;
      proc_idx_r <= proc_idx_nxt;
      hit_r      <= hit_nxt;
      free_vld_r <= free_vld_nxt;
      free_idx_r <= free_idx_nxt;
      oor_r      <= oor_nxt;
      removed_r  <= removed_nxt;
      total_r    <= total_nxt;
      valid_r    <= valid_nxt;
      out_vld_r  <= out_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    port_r   <= port_nxt;
    rid_r    <= rid_nxt;
    addr_r   <= addr_nxt;
    mask_r   <= mask_nxt;
    o_chg_r  <= o_chg_nxt;
    o_add_r  <= o_add_nxt;
    o_rem_r  <= o_rem_nxt;
    o_nbr_r  <= o_nbr_nxt;
    o_drop_r <= o_drop_nxt;
  end

  assign busy               = state_r != ST_IDLE;
  assign out_valid          = out_vld_r;
  assign out_set_changed    = o_chg_r;
  assign out_was_added      = o_add_r;
  assign out_removed_count  = o_rem_r;
  assign out_port_neighbors = o_nbr_r;
  assign out_insert_dropped = o_drop_r;

`ifndef SYNTH
  // the running total must track the live slots
  a_total_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (int'(total_r) == $countones(valid_r)))
    else $error("neighbour total differs from live slot count");

  a_fin_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> out_vld_r)
    else $error("finish step without result strobe");

  a_add_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(o_add_r && o_drop_r))
    else $error("result both added and dropped");

  a_add_changes_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && o_add_r) |-> o_chg_r)
    else $error("insert without set change");
`endif

endmodule

`default_nettype wire

[design/neighbor_table_with_aging_top.sv]
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_top
// Shared neighbour table with per-entry age and dead-interval expiry.
// ----------------------------------------------------------------------------
// Usage: pulse start with busy low to hand over a hello or a tick. The engine
// walks the slot RAM one entry per clock through its single read port, so a
// hello or tick keeps busy high through the walk and a finish step, and its
// result strobes on out_valid for one cycle, in which busy is already low, so
// the next item can be started then. A hello on a port outside the table's
// port range skips the walk and returns all zeros. The result cannot be held
// off; sample it when out_valid is high. A hello stops its walk early once the
// neighbour is found. Write hello_interval only while busy is low and no
// result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_table_with_aging_top #(
  parameter int TABLE_ENTRIES = nbr_pkg::TABLE_ENTRIES_DEF,
  parameter int PORT_COUNT    = nbr_pkg::PORT_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_req_type,
  input  wire logic [nbr_pkg::PORT_W-1:0] in_port_index,
  input  wire logic [31:0]                in_router_id,
  input  wire logic [31:0]                in_source_address,
  input  wire logic [31:0]                in_network_mask,
  output logic                            out_valid,
  output logic                            out_set_changed,
  output logic                            out_was_added,
  output logic [nbr_pkg::OUT_W-1:0]       out_removed_count,
  output logic [nbr_pkg::OUT_W-1:0]       out_port_neighbors,
  output logic                            out_insert_dropped
);
  import nbr_pkg::*;

  logic [7:0] hello_interval;

  nbr_apb u_apb (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .hello_interval (hello_interval)
  );

  nbr_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PORT_COUNT    (PORT_COUNT)
  ) u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .hello_interval     (hello_interval),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_port_index      (in_port_index),
    .in_router_id       (in_router_id),
    .in_source_address  (in_source_address),
    .in_network_mask    (in_network_mask),
    .out_valid          (out_valid),
    .out_set_changed    (out_set_changed),
    .out_was_added      (out_was_added),
    .out_removed_count  (out_removed_count),
    .out_port_neighbors (out_port_neighbors),
    .out_insert_dropped (out_insert_dropped)
  );

endmodule

`default_nettype wire

[test/nbr_table_sb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nbr_table_sb_pkg
// Shadow copy of the shared neighbour table with its ages. It predicts the
// reply to each accepted hello or tick and checks the replies in order.
// ----------------------------------------------------------------------------

package nbr_table_sb_pkg;

  import nbr_pkg::*;

  localparam int NBR_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int NBR_PORTS   = PORT_COUNT_DEF;

  typedef struct {
    req_t              kind;
    logic [PORT_W-1:0] port;
    logic [31:0]       router;
    logic [31:0]       address;
    logic [31:0]       mask;
  } nbr_request_t;

  typedef struct {
    logic             set_changed;
    logic             was_added;
    logic [OUT_W-1:0] removed_count;
    logic [OUT_W-1:0] port_neighbors;
    logic             insert_dropped;
  } nbr_reply_t;

  class nbr_table_shadow;
    bit [7:0]         interval;
    bit               entry_used [NBR_ENTRIES];
    bit [PORT_W-1:0]  entry_port [NBR_ENTRIES];
    bit [31:0]        entry_router [NBR_ENTRIES];
    bit [AGE_W-1:0]   entry_age [NBR_ENTRIES];
    int unsigned      port_nbrs [NBR_PORTS];
    nbr_reply_t       expected_replies [$];
    int unsigned      errors;

    function new();
      interval = HELLO_INTERVAL_RST;
      errors   = 0;
      foreach (entry_used[i]) entry_used[i] = 1'b0;
      foreach (port_nbrs[i]) port_nbrs[i] = 0;
    endfunction

    function void set_interval(bit [7:0] v);
      interval = v;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function bit [OUT_W-1:0] clamp_count(int unsigned n);
      return (n > 31) ? 5'd31 : n[OUT_W-1:0];
    endfunction

    function void note_request(nbr_request_t rq);
      nbr_reply_t  r;
      int unsigned dead_after;
      int unsigned removed;
      int unsigned total;
      int          hit;
      int          free_idx;
      r = '{default: '0};
      if (rq.kind == REQ_TICK) begin
        dead_after = DEAD_FACTOR * int'(interval);
        removed    = 0;
        total      = 0;
        for (int i = 0; i < NBR_ENTRIES; i++) begin
          if (entry_used[i]) begin
            if (entry_age[i] != AGE_MAX) entry_age[i] = entry_age[i] + 1'b1;
            if (int'(entry_age[i]) > dead_after) begin
              entry_used[i] = 1'b0;
              if (port_nbrs[entry_port[i]] > 0) port_nbrs[entry_port[i]]--;
              removed++;
            end
          end
        end
        foreach (port_nbrs[p]) total += port_nbrs[p];
        r.set_changed    = (removed > 0);
        r.removed_count  = clamp_count(removed);
        r.port_neighbors = clamp_count(total);
      end else if (int'(rq.port) < NBR_PORTS) begin
        hit      = -1;
        free_idx = -1;
        for (int i = 0; i < NBR_ENTRIES; i++) begin
          if (entry_used[i] && entry_port[i] == rq.port && entry_router[i] == rq.router &&
              hit < 0) begin
            hit = i;
          end
          if (!entry_used[i] && free_idx < 0) free_idx = i;
        end
        if (hit >= 0) begin
          entry_age[hit] = '0;
        end else if (free_idx >= 0) begin
          entry_used[free_idx]   = 1'b1;
          entry_port[free_idx]   = rq.port;
          entry_router[free_idx] = rq.router;
          entry_age[free_idx]    = '0;
          port_nbrs[rq.port]++;
          r.set_changed = 1'b1;
          r.was_added   = 1'b1;
        end else begin
          r.insert_dropped = 1'b1;
        end
        r.port_neighbors = clamp_count(port_nbrs[rq.port]);
      end
      expected_replies.push_back(r);
    endfunction

    function void check_reply(nbr_reply_t got);
      nbr_reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected reply chg=%0b add=%0b rem=%0d nbrs=%0d drop=%0b",
                   got.set_changed, got.was_added, got.removed_count,
                   got.port_neighbors, got.insert_dropped);
        return;
      end
      want = expected_replies.pop_front();
      if (got.set_changed !== want.set_changed || got.was_added !== want.was_added ||
          got.removed_count !== want.removed_count ||
          got.port_neighbors !== want.port_neighbors ||
          got.insert_dropped !== want.insert_dropped) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: reply mismatch exp chg=%0b add=%0b rem=%0d nbrs=%0d drop=%0b",
                   want.set_changed, want.was_added, want.removed_count,
                   want.port_neighbors, want.insert_dropped);
          $display("       got chg=%0b add=%0b rem=%0d nbrs=%0d drop=%0b",
                   got.set_changed, got.was_added, got.removed_count,
                   got.port_neighbors, got.insert_dropped);
        end
      end
    endfunction
  endclass

endpackage

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Neighbour table with aging: directed hellos and ticks (extremes, known
// neighbour, full table, zero interval) then random traffic over several
// hello intervals and sender idle rates, checked against a shadow table.
// ----------------------------------------------------------------------------

module tb_top;

  import nbr_pkg::*;
  import nbr_table_sb_pkg::*;

  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PHASE_ITEMS   = 105;
  localparam int          ROUTER_POOL   = 20;
  localparam logic [2:0]  INTERVAL_ADDR = {REG_HELLO_INTERVAL, 2'b00};

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 start;
  logic                 busy;
  logic                 in_req_type;
  logic [PORT_W-1:0]    in_port_index;
  logic [31:0]          in_router_id;
  logic [31:0]          in_source_address;
  logic [31:0]          in_network_mask;
  logic                 out_valid;
  logic                 out_set_changed;
  logic                 out_was_added;
  logic [OUT_W-1:0]     out_removed_count;
  logic [OUT_W-1:0]     out_port_neighbors;
  logic                 out_insert_dropped;

  nbr_table_shadow sb = new();
  int unsigned     sender_idle_pct;
  int unsigned     cycle_count;
  logic [31:0]     router_pool [ROUTER_POOL];

  neighbor_table_with_aging_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_port_index      (in_port_index),
    .in_router_id       (in_router_id),
    .in_source_address  (in_source_address),
    .in_network_mask    (in_network_mask),
    .out_valid          (out_valid),
    .out_set_changed    (out_set_changed),
    .out_was_added      (out_was_added),
    .out_removed_count  (out_removed_count),
    .out_port_neighbors (out_port_neighbors),
    .out_insert_dropped (out_insert_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL neighbor_table_with_aging_top");
      $finish;
    end
  end

  // check the reply before noting a transfer taken at the same edge
  always @(posedge clk) begin : monitor
    nbr_reply_t   got;
    nbr_request_t taken;
    if (rst_n) begin
      if (out_valid) begin
        got.set_changed    = out_set_changed;
        got.was_added      = out_was_added;
        got.removed_count  = out_removed_count;
        got.port_neighbors = out_port_neighbors;
        got.insert_dropped = out_insert_dropped;
        sb.check_reply(got);
      end
      if (start && !busy) begin
        taken.kind    = req_t'(in_req_type);
        taken.port    = in_port_index;
        taken.router  = in_router_id;
        taken.address = in_source_address;
        taken.mask    = in_network_mask;
        sb.note_request(taken);
      end
    end
  end

  function automatic nbr_request_t make_hello(logic [PORT_W-1:0] port, logic [31:0] router,
                                              logic [31:0] address, logic [31:0] mask);
    nbr_request_t rq;
    rq.kind    = REQ_HELLO;
    rq.port    = port;
    rq.router  = router;
    rq.address = address;
    rq.mask    = mask;
    return rq;
  endfunction

  function automatic nbr_request_t make_tick();
    nbr_request_t rq;
    rq.kind    = REQ_TICK;
    rq.port    = PORT_W'($urandom());
    rq.router  = $urandom();
    rq.address = $urandom();
    rq.mask    = $urandom();
    return rq;
  endfunction

  // called just after a falling edge; returns just after a falling edge
  task automatic send_request(input nbr_request_t rq);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start             <= 1'b1;
    in_req_type       <= rq.kind;
    in_port_index     <= rq.port;
    in_router_id      <= rq.router;
    in_source_address <= rq.address;
    in_network_mask   <= rq.mask;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_interval(input logic [7:0] value);
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= INTERVAL_ADDR;
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_interval(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] interval, input int unsigned idle_pct);
    nbr_request_t rq;
    write_interval(interval);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(99) < 30) begin
        rq = make_tick();
      end else begin
        rq = make_hello(PORT_W'($urandom()),
                        ($urandom_range(99) < 85) ? router_pool[$urandom_range(ROUTER_POOL-1)]
                                                  : $urandom(),
                        $urandom(), $urandom());
      end
      send_request(rq);
    end
  endtask

  initial begin
    cycle_count       = 0;
    sender_idle_pct   = 0;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    start             = 1'b0;
    in_req_type       = REQ_HELLO;
    in_port_index     = '0;
    in_router_id      = '0;
    in_source_address = '0;
    in_network_mask   = '0;
    router_pool[0]    = 32'h0000_0000;
    router_pool[1]    = 32'hFFFF_FFFF;
    for (int i = 2; i < ROUTER_POOL; i++) router_pool[i] = $urandom();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // field extremes, same router on two ports, known neighbour, one tick
    send_request(make_hello(2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send_request(make_hello(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_hello(2'd1, 32'h0000_0000, 32'hC0A8_0001, 32'hFFFF_FF00));
    send_request(make_hello(2'd2, 32'h5A5A_A5A5, 32'h0A00_0002, 32'hFF00_0000));
    send_request(make_hello(2'd0, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFC));
    send_request(make_tick());
    // fill the table, then a new neighbour is dropped and a known one refreshed
    for (int i = 0; i < NBR_ENTRIES - 4; i++)
      send_request(make_hello(PORT_W'(i), 32'h1000_0000 + i, $urandom(), $urandom()));
    send_request(make_hello(2'd1, 32'hDEAD_0001, $urandom(), $urandom()));
    send_request(make_hello(2'd0, 32'h0000_0000, $urandom(), $urandom()));
    // zero interval: everything expires on the next tick
    write_interval(8'd0);
    send_request(make_tick());
    send_request(make_hello(2'd2, 32'h7FFF_FFFF, $urandom(), $urandom()));
    send_request(make_tick());

    run_phase(8'd1, 0);
    run_phase(8'd2, 57);
    run_phase(8'd255, 21);
    run_phase(8'd0, 0);
    run_phase(8'd3, 57);
    run_phase(8'($urandom_range(1, 8)), 21);

    wait_idle();
    repeat (NBR_ENTRIES + 5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS neighbor_table_with_aging_top");
    end else begin
      $display("FAIL neighbor_table_with_aging_top");
    end
    $finish;
  end

endmodule
